### sv/sm4_block_cipher_unit_macros.svh
// Assertion macros for the SM4 block cipher unit.
// Included by the top level; the enclosing module must provide clk and rst_n.
`ifndef SM4_BLOCK_CIPHER_UNIT_MACROS_SVH
`define SM4_BLOCK_CIPHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sm4_pkg.sv
// Shared types, constants and functions of the SM4 block cipher unit.
// Used by the round key RAM, the key schedule, the round core and the top level.
package sm4_pkg;

  localparam int NUM_ROUNDS = 32;
  localparam int RK_ADDR_W  = $clog2(NUM_ROUNDS);

  typedef logic [31:0]          word_t;
  typedef logic [RK_ADDR_W-1:0] rk_addr_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_MODE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KS_INIT,
    KS_RUN,
    KS_IDLE
  } ks_state_t;

  typedef enum logic [1:0] {
    RC_IDLE,
    RC_RUN,
    RC_DONE
  } rc_state_t;

  typedef struct packed {
    logic     we;
    rk_addr_t addr;
    word_t    data;
  } rk_wr_t;

  localparam word_t FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  function automatic word_t tau(input word_t a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic word_t l_data(input word_t b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

  function automatic word_t l_key(input word_t b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  function automatic logic [7:0] ck_byte(input logic [7:0] t);
    logic [10:0] p;
    p = {3'b000, t} * 11'd7;
    return p[7:0];
  endfunction

  // Byte j of constant i is (4*i + j) * 7 modulo 256, byte 0 most significant.
  function automatic word_t ck(input rk_addr_t i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    return {ck_byte(base), ck_byte(base + 8'd1), ck_byte(base + 8'd2), ck_byte(base + 8'd3)};
  endfunction

endpackage

### sv/sm4_block_cipher_unit.sv
// SM4 block cipher unit, ECB mode, one 128-bit block per beat.
// Holds the configuration registers and connects key schedule, round key
// memory and round core. Depends on sm4_pkg and the assertion macro header.
//
// Usage: the configuration channel writes key_high (index 0), key_low
// (index 1) and decrypt_mode (index 2); it is always ready and a write to
// any other index is ignored. Each key write starts a new key expansion,
// one round key per cycle into the round key memory, during which in_ready
// stays low. After reset the expansion of the all-zero key runs the same
// way. Configuration must be changed only while no block is in flight; the
// unit does not enforce this. An input beat carries one block and its
// last-block flag. The round core runs one round per cycle through a single
// round unit fed by the round key memory; after the last round it waits
// until the output register is free, loads the result there and only then
// takes the next input beat. The output register holds the result while
// out_ready is low; a block that finishes meanwhile waits in the core.
`include "sm4_block_cipher_unit_macros.svh"
module sm4_block_cipher_unit
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic        out_last
);

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic        decrypt_mode_r;
  logic        cfg_wr;
  logic        key_wr;
  logic        key_busy;
  rk_wr_t      rk_wr;
  rk_addr_t    rd_addr;
  word_t       rd_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_wr    = cfg_wr && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r     <= '0;
      key_low_r      <= '0;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_KEY_HIGH: key_high_r     <= cfg_data;
        CFG_KEY_LOW:  key_low_r      <= cfg_data;
        CFG_MODE:     decrypt_mode_r <= cfg_data[0];
        default:      decrypt_mode_r <= decrypt_mode_r;
      endcase
    end
  end

  sm4_key_sched u_key_sched (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (key_wr),
    .key_high (key_high_r),
    .key_low  (key_low_r),
    .busy     (key_busy),
    .rk_wr    (rk_wr)
  );

  sm4_rk_ram u_rk_ram (
    .clk     (clk),
    .wr      (rk_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sm4_round_core u_round_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .decrypt_mode  (decrypt_mode_r),
    .key_busy      (key_busy),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_block_high (in_block_high),
    .in_block_low  (in_block_low),
    .in_last_block (in_last_block),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_high      (out_high),
    .out_low       (out_low),
    .out_last      (out_last)
  );

  `SM4_ASSERT_SAME(a_no_accept_during_expansion, in_ready, !key_busy,
    "input accepted while round keys are being expanded")
  `SM4_ASSERT_NEXT(a_key_write_blocks_input, key_wr, !in_ready && key_busy,
    "key write did not start a new expansion")
  `SM4_ASSERT_NEXT(a_one_block_at_a_time, in_valid && in_ready, !in_ready,
    "second block accepted while a block is in the rounds")

endmodule

### sv/sm4_rk_ram.sv
// Round key memory: 32 words, one write port, one registered read port.
// Depends on sm4_pkg for the word, address and write port types.
module sm4_rk_ram
  import sm4_pkg::*;
(
  input  logic     clk,
  input  rk_wr_t   wr,
  input  rk_addr_t rd_addr,
  output word_t    rd_data
);

  word_t mem [NUM_ROUNDS];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sm4_key_sched.sv
// Key schedule: expands the 128-bit key into 32 round keys, one per cycle,
// and writes them into the round key memory. Depends on sm4_pkg.
module sm4_key_sched
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        restart,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  output logic        busy,
  output rk_wr_t      rk_wr
);

  ks_state_t state_r, state_nxt;
  rk_addr_t  cnt_r;
  word_t     k_r [4];
  word_t     nk;
  logic      last_round;

  assign nk         = k_r[0] ^ l_key(tau(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck(cnt_r)));
  assign last_round = (cnt_r == rk_addr_t'(NUM_ROUNDS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KS_INIT: state_nxt = KS_RUN;
      KS_RUN:  if (last_round) begin
        state_nxt = KS_IDLE;
      end
      KS_IDLE: state_nxt = KS_IDLE;
      default: state_nxt = KS_INIT;
    endcase
    if (restart) begin
      state_nxt = KS_INIT;
    end
  end

  always_comb begin
    busy        = (state_r != KS_IDLE);
    rk_wr.we    = (state_r == KS_RUN);
    rk_wr.addr  = cnt_r;
    rk_wr.data  = nk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == KS_INIT) begin
        cnt_r <= '0;
      end else if (state_r == KS_RUN) begin
        cnt_r <= cnt_r + rk_addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == KS_INIT) begin
      k_r[0] <= key_high[63:32] ^ FK[0];
      k_r[1] <= key_high[31:0] ^ FK[1];
      k_r[2] <= key_low[63:32] ^ FK[2];
      k_r[3] <= key_low[31:0] ^ FK[3];
    end else if (state_r == KS_RUN) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= nk;
    end
  end

endmodule

### sv/sm4_round_core.sv
// Round core: runs 32 SM4 rounds on one block, one round per cycle, with the
// round keys read from the round key memory. Depends on sm4_pkg.
module sm4_round_core
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        decrypt_mode,
  input  logic        key_busy,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_last_block,
  output rk_addr_t    rd_addr,
  input  word_t       rd_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic        out_last
);

  rc_state_t   state_r, state_nxt;
  rk_addr_t    rnd_r;
  word_t       x_r [4];
  logic        last_r;
  logic        out_valid_r;
  logic [63:0] out_high_r;
  logic [63:0] out_low_r;
  logic        out_last_r;
  word_t       nx;
  logic        load_in;
  logic        step;
  logic        load_out;
  logic        out_free;
  rk_addr_t    rnd_sel;

  assign nx       = x_r[0] ^ l_data(tau(x_r[1] ^ x_r[2] ^ x_r[3] ^ rd_data));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RC_IDLE: if (in_valid && !key_busy) begin
        state_nxt = RC_RUN;
      end
      RC_RUN:  if (rnd_r == rk_addr_t'(NUM_ROUNDS - 1)) begin
        state_nxt = RC_DONE;
      end
      RC_DONE: if (out_free) begin
        state_nxt = RC_IDLE;
      end
      default: state_nxt = RC_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    rnd_sel  = '0;
    case (state_r)
      RC_IDLE: in_ready = !key_busy;
      RC_RUN:  begin
        step    = 1'b1;
        rnd_sel = rnd_r + rk_addr_t'(1);
      end
      RC_DONE: load_out = out_free;
      default: in_ready = 1'b0;
    endcase
    load_in = in_valid && in_ready;
    rd_addr = decrypt_mode ? ~rnd_sel : rnd_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RC_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_in) begin
        rnd_r <= '0;
      end else if (step) begin
        rnd_r <= rnd_r + rk_addr_t'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      x_r[0] <= in_block_high[63:32];
      x_r[1] <= in_block_high[31:0];
      x_r[2] <= in_block_low[63:32];
      x_r[3] <= in_block_low[31:0];
      last_r <= in_last_block;
    end else if (step) begin
      x_r[0] <= x_r[1];
      x_r[1] <= x_r[2];
      x_r[2] <= x_r[3];
      x_r[3] <= nx;
    end
    if (load_out) begin
      out_high_r <= {x_r[3], x_r[2]};
      out_low_r  <= {x_r[1], x_r[0]};
      out_last_r <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_high  = out_high_r;
  assign out_low   = out_low_r;
  assign out_last  = out_last_r;

endmodule
